// ===== src/ngt_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ngt_pkg
// Shared widths, codes, reset values and structures of the NACK gap table.
// ============================================================================
package ngt_pkg;

    // Default table depth; the top level takes it as a parameter.
    localparam int GAP_ENTRIES_DEF = 32;

    localparam int SEQ_W      = 32;
    localparam int TIME_W     = 32;
    localparam int CFG_W      = 16;
    localparam int FUNC_W     = 2;
    localparam int CNT_W      = 6;
    localparam int CFG_ADDR_W = 2;

    // Stream payload widths.
    localparam int S_TDATA_W = SEQ_W + TIME_W;
    localparam int S_TUSER_W = FUNC_W;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - SEQ_W - CNT_W;
    localparam int M_TUSER_W = 1;

    // Item kinds.
    localparam logic [FUNC_W-1:0] FUNC_OPEN  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLOSE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_GRACE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RETRY  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_EXPIRE = 2'd2;

    localparam logic [CFG_W-1:0] GRACE_RST  = 16'd0;
    localparam logic [CFG_W-1:0] RETRY_RST  = 16'd25;
    localparam logic [CFG_W-1:0] EXPIRE_RST = 16'd200;

    typedef struct packed {
        logic [CFG_W-1:0] grace;
        logic [CFG_W-1:0] retry;
        logic [CFG_W-1:0] expire;
    } t_cfg;

    // One entry as read from the table.
    typedef struct packed {
        logic              active;
        logic              nacked;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] created;
        logic [TIME_W-1:0] last_nack;
    } t_ent_rd;

    // Write command to the table; at most one of the three strobes is set.
    typedef struct packed {
        logic              wr_new;
        logic              wr_stamp;
        logic              wr_clr;
        logic              nacked;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] created;
        logic [TIME_W-1:0] last_nack;
    } t_ent_wr;

    // Results of the shared time unit for one entry.
    typedef struct packed {
        logic [TIME_W-1:0] age;
        logic              expired;
        logic              in_grace;
        logic              retry_due;
        logic              older;
    } t_age_res;

endpackage

// ===== src/nack_gap_table_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// nack_gap_table_core
// Table of missing sequence numbers that schedules retransmission requests.
// ============================================================================
//
//  Channel   Dir  Handshake          Contents
//  --------  ---  -----------------  -----------------------------------------
//  s_axis    in   tvalid / tready    tuser: func; tdata: seq_num, now_ms
//  m_axis    out  tvalid / tready    tuser: nack_valid; tdata: nack_seq,
//                                    active_count; tlast: last
//  cfg       in   write enable only  addr 0 grace, 1 retry, 2 expire time
//
// Every open, close or tick item walks the whole table, one entry per cycle
// through the single read port of the entry memories and the shared time
// unit; an open then writes back its entry in ST_FIN. Any other item goes
// straight to its closing result. A held result on m_axis stalls the
// walk until it is taken. Reset is synchronous and clears the control state,
// the active and nacked flags and the configuration; no clearing pass is
// needed. s_axis is ready only between items.
//
module nack_gap_table_core #(
    parameter int GAP_ENTRIES = ngt_pkg::GAP_ENTRIES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input stream.
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [ngt_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,  // seq_num, now_ms
    input  logic [ngt_pkg::S_TUSER_W-1:0]    i_s_axis_tuser,  // func
    // Result stream.
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [ngt_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,  // nack_seq, active_count, pad
    output logic [ngt_pkg::M_TUSER_W-1:0]    o_m_axis_tuser,  // nack_valid
    output logic                             o_m_axis_tlast,
    // Configuration writes.
    input  logic                             i_cfg_we,
    input  logic [ngt_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [ngt_pkg::CFG_W-1:0]        i_cfg_wdata
);
    import ngt_pkg::*;

    localparam int IDX_W = $clog2(GAP_ENTRIES);
    localparam int CW    = $clog2(GAP_ENTRIES + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_FIN  = 4'b0100,
        ST_LAST = 4'b1000
    } t_state;

    t_state r_state, n_state;

    t_cfg              r_cfg;
    logic [FUNC_W-1:0] r_func;
    logic [SEQ_W-1:0]  r_seq;
    logic [TIME_W-1:0] r_now;

    // Scan pointers: r_ia is the next address issued, r_kd the entry whose
    // read data is on the table output when r_dv is set.
    logic [CW-1:0]     r_ia,    n_ia;
    logic              r_dv,    n_dv;
    logic [IDX_W-1:0]  r_kd,    n_kd;
    logic [CW-1:0]     r_count, n_count;

    // Open bookkeeping: first match, first free entry, oldest entry.
    logic              r_match, n_match;
    logic [IDX_W-1:0]  r_midx,  n_midx;
    logic              r_free,  n_free;
    logic [IDX_W-1:0]  r_fidx,  n_fidx;
    logic [TIME_W-1:0] r_best,  n_best;
    logic [IDX_W-1:0]  r_bidx,  n_bidx;

    // Output register.
    logic              r_out_vld;
    logic              r_out_nack;
    logic [SEQ_W-1:0]  r_out_seq;
    logic [CNT_W-1:0]  r_out_cnt;
    logic              r_out_last;

    logic              w_slot;
    logic              w_accept;
    logic              w_rd_en;
    logic [IDX_W-1:0]  w_rd_idx;
    t_ent_rd           w_rd;
    t_ent_wr           w_wr;
    logic [IDX_W-1:0]  w_wr_idx;
    t_age_res          w_age;
    logic              w_hit;
    logic              w_grace0;
    logic              w_emit;
    logic              w_emit_last;
    logic [SEQ_W-1:0]  w_emit_seq;

    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    // A new result may be loaded when the output register is empty or is
    // being emptied in this cycle.
    assign w_slot          = !r_out_vld || i_m_axis_tready;
    assign w_hit           = w_rd.active && (w_rd.seq == r_seq);
    assign w_grace0        = (r_cfg.grace == '0);
    assign w_rd_idx        = r_ia[IDX_W-1:0];

    ngt_table #(
        .GAP_ENTRIES (GAP_ENTRIES)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (w_rd_en),
        .i_rd_idx (w_rd_idx),
        .o_rd     (w_rd),
        .i_wr     (w_wr),
        .i_wr_idx (w_wr_idx)
    );

    ngt_age_unit u_age (
        .i_now       (r_now),
        .i_created   (w_rd.created),
        .i_last_nack (w_rd.last_nack),
        .i_best      (r_best),
        .i_cfg       (r_cfg),
        .o_res       (w_age)
    );

    // Configuration registers; writes to an unknown index are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grace  <= GRACE_RST;
            r_cfg.retry  <= RETRY_RST;
            r_cfg.expire <= EXPIRE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_GRACE:  r_cfg.grace  <= i_cfg_wdata;
                REG_RETRY:  r_cfg.retry  <= i_cfg_wdata;
                REG_EXPIRE: r_cfg.expire <= i_cfg_wdata;
                default:    ;
            endcase
        end
    end

    // The item is held for the whole walk.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= i_s_axis_tuser;
            r_seq  <= i_s_axis_tdata[SEQ_W-1:0];
            r_now  <= i_s_axis_tdata[S_TDATA_W-1:SEQ_W];
        end
    end

    // Sequencer. Each scan cycle with a free output slot issues at most one
    // read and decides on the entry of the previous read; writes never hit the
    // entry being read. The open write-back happens in ST_FIN once the walk is over.
    always_comb begin
        n_state     = r_state;
        n_ia        = r_ia;
        n_dv        = r_dv;
        n_kd        = r_kd;
        n_count     = r_count;
        n_match     = r_match;
        n_midx      = r_midx;
        n_free      = r_free;
        n_fidx      = r_fidx;
        n_best      = r_best;
        n_bidx      = r_bidx;
        w_rd_en     = 1'b0;
        w_wr        = '0;
        w_wr_idx    = r_kd;
        w_emit      = 1'b0;
        w_emit_last = 1'b0;
        w_emit_seq  = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_ia    = '0;
                    n_dv    = 1'b0;
                    n_kd    = '0;
                    n_match = 1'b0;
                    n_midx  = '0;
                    n_free  = 1'b0;
                    n_fidx  = '0;
                    n_best  = '0;
                    n_bidx  = '0;
                    if (i_s_axis_tuser == FUNC_OPEN || i_s_axis_tuser == FUNC_CLOSE ||
                        i_s_axis_tuser == FUNC_TICK) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_LAST;
                    end
                end
            end

            ST_SCAN: begin
                if (w_slot) begin
                    w_rd_en = (r_ia != CW'(GAP_ENTRIES));
                    n_dv    = w_rd_en;
                    n_kd    = r_ia[IDX_W-1:0];
                    if (w_rd_en) begin
                        n_ia = r_ia + CW'(1);
                    end
                    if (r_dv) begin
                        priority if (r_func == FUNC_OPEN) begin
                            if (w_hit && !r_match) begin
                                n_match = 1'b1;
                                n_midx  = r_kd;
                            end
                            if (!w_rd.active && !r_free) begin
                                n_free = 1'b1;
                                n_fidx = r_kd;
                            end
                            // Oldest entry; strict compare keeps the lowest
                            // index on a tie. Only used when all are active.
                            if (r_kd == '0 || w_age.older) begin
                                n_best = w_age.age;
                                n_bidx = r_kd;
                            end
                        end else if (r_func == FUNC_CLOSE) begin
                            if (w_hit) begin
                                w_wr.wr_clr = 1'b1;
                                n_count     = r_count - CW'(1);
                            end
                        end else begin
                            if (w_rd.active) begin
                                w_wr.last_nack = r_now;
                                w_wr.nacked    = 1'b1;
                                if (w_age.expired) begin
                                    w_wr.wr_clr = 1'b1;
                                    n_count     = r_count - CW'(1);
                                end else if (w_age.in_grace) begin
                                    w_wr.wr_clr = 1'b0;
                                end else if (!w_rd.nacked || w_age.retry_due) begin
                                    w_wr.wr_stamp = 1'b1;
                                    w_emit        = 1'b1;
                                    w_emit_seq    = w_rd.seq;
                                end
                            end
                        end
                        if (r_kd == IDX_W'(GAP_ENTRIES - 1)) begin
                            n_state = (r_func == FUNC_OPEN) ? ST_FIN : ST_LAST;
                        end
                    end
                end
            end

            ST_FIN: begin
                if (w_slot) begin
                    w_wr.seq     = r_seq;
                    w_wr.created = r_now;
                    w_wr.nacked  = w_grace0;
                    if (r_match) begin
                        // Sequence already open: only a zero grace time
                        // requests it again and stamps the first match.
                        w_wr_idx       = r_midx;
                        w_wr.last_nack = r_now;
                        w_wr.wr_stamp  = w_grace0;
                    end else begin
                        w_wr_idx       = r_free ? r_fidx : r_bidx;
                        w_wr.last_nack = w_grace0 ? r_now : '0;
                        w_wr.wr_new    = 1'b1;
                        if (r_free) begin
                            n_count = r_count + CW'(1);
                        end
                    end
                    w_emit     = w_grace0;
                    w_emit_seq = r_seq;
                    n_state    = ST_LAST;
                end
            end

            ST_LAST: begin
                if (w_slot) begin
                    w_emit      = 1'b1;
                    w_emit_last = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ia    <= '0;
            r_dv    <= 1'b0;
            r_count <= '0;
            r_match <= 1'b0;
            r_free  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ia    <= n_ia;
            r_dv    <= n_dv;
            r_count <= n_count;
            r_match <= n_match;
            r_free  <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kd   <= n_kd;
        r_midx <= n_midx;
        r_fidx <= n_fidx;
        r_best <= n_best;
        r_bidx <= n_bidx;
    end

    // Output register: loaded only when the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_emit) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_nack <= !w_emit_last;
            r_out_seq  <= w_emit_seq;
            r_out_cnt  <= w_emit_last ? CNT_W'(n_count) : '0;
            r_out_last <= w_emit_last;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{M_PAD_W{1'b0}}, r_out_cnt, r_out_seq};
    assign o_m_axis_tuser  = r_out_nack;
    assign o_m_axis_tlast  = r_out_last;

endmodule

// ===== src/ngt_age_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ngt_age_unit
// Shared modulo-2^32 time arithmetic used by every scan step.
// ============================================================================
module ngt_age_unit (
    input  logic [ngt_pkg::TIME_W-1:0] i_now,
    input  logic [ngt_pkg::TIME_W-1:0] i_created,
    input  logic [ngt_pkg::TIME_W-1:0] i_last_nack,
    input  logic [ngt_pkg::TIME_W-1:0] i_best,
    input  ngt_pkg::t_cfg              i_cfg,
    output ngt_pkg::t_age_res          o_res
);
    import ngt_pkg::*;

    logic [TIME_W-1:0] w_age;
    logic [TIME_W-1:0] w_since;

    // Both differences wrap, so a plain subtraction is exact.
    assign w_age   = i_now - i_created;
    assign w_since = i_now - i_last_nack;

    always_comb begin
        o_res.age       = w_age;
        o_res.expired   = w_age > TIME_W'(i_cfg.expire);
        o_res.in_grace  = w_age < TIME_W'(i_cfg.grace);
        o_res.retry_due = w_since >= TIME_W'(i_cfg.retry);
        o_res.older     = w_age > i_best;
    end

endmodule

// ===== src/ngt_table.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ngt_table
// Gap entry storage: three word memories plus active and nacked flags.
// ============================================================================
module ngt_table #(
    parameter int GAP_ENTRIES = ngt_pkg::GAP_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_rd_en,
    input  logic [$clog2(GAP_ENTRIES)-1:0] i_rd_idx,
    output ngt_pkg::t_ent_rd               o_rd,
    input  ngt_pkg::t_ent_wr               i_wr,
    input  logic [$clog2(GAP_ENTRIES)-1:0] i_wr_idx
);
    import ngt_pkg::*;

    logic [SEQ_W-1:0]  r_seq_mem  [GAP_ENTRIES];
    logic [TIME_W-1:0] r_crt_mem  [GAP_ENTRIES];
    logic [TIME_W-1:0] r_last_mem [GAP_ENTRIES];

    logic [GAP_ENTRIES-1:0] r_active;
    logic [GAP_ENTRIES-1:0] r_nacked;

    logic              r_rd_active;
    logic              r_rd_nacked;
    logic [SEQ_W-1:0]  r_rd_seq;
    logic [TIME_W-1:0] r_rd_crt;
    logic [TIME_W-1:0] r_rd_last;

    always_ff @(posedge i_clk) begin
        if (i_wr.wr_new) begin
            r_seq_mem[i_wr_idx] <= i_wr.seq;
        end
        if (i_rd_en) begin
            r_rd_seq <= r_seq_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.wr_new) begin
            r_crt_mem[i_wr_idx] <= i_wr.created;
        end
        if (i_rd_en) begin
            r_rd_crt <= r_crt_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.wr_new || i_wr.wr_stamp) begin
            r_last_mem[i_wr_idx] <= i_wr.last_nack;
        end
        if (i_rd_en) begin
            r_rd_last <= r_last_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_nacked <= '0;
        end else begin
            if (i_wr.wr_new) begin
                r_active[i_wr_idx] <= 1'b1;
                r_nacked[i_wr_idx] <= i_wr.nacked;
            end else if (i_wr.wr_stamp) begin
                r_nacked[i_wr_idx] <= 1'b1;
            end else if (i_wr.wr_clr) begin
                r_active[i_wr_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_active <= r_active[i_rd_idx];
            r_rd_nacked <= r_nacked[i_rd_idx];
        end
    end

    always_comb begin
        o_rd.active    = r_rd_active;
        o_rd.nacked    = r_rd_nacked;
        o_rd.seq       = r_rd_seq;
        o_rd.created   = r_rd_crt;
        o_rd.last_nack = r_rd_last;
    end

endmodule

// ===== src/ngt_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ngt_checker
// Port-level checks of the NACK gap table, bound to the top level.
// ============================================================================
module ngt_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_axis_tvalid,
    input logic                           o_s_axis_tready,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [ngt_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    input logic [ngt_pkg::M_TUSER_W-1:0]  o_m_axis_tuser,
    input logic                           o_m_axis_tlast
);
    import ngt_pkg::*;

    // A held result keeps its contents until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    // One item at a time: the block is busy after every input transfer.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("ready stayed high after an input transfer");

    // A result is either a request or the closing result, never both.
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast != o_m_axis_tuser[0]))
        else $error("request flag and last flag disagree");

    // Requests carry no count; closing results carry no sequence number.
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tlast || o_m_axis_tdata[SEQ_W+CNT_W-1:SEQ_W] == '0) &&
            (!o_m_axis_tlast || o_m_axis_tdata[SEQ_W-1:0] == '0))
        else $error("unused result field not zero");

    // The block becomes ready again just as the closing result is loaded.
    a_ready_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_s_axis_tready) && $past(i_rst_n) |-> o_m_axis_tvalid && o_m_axis_tlast)
        else $error("ready returned without a closing result");

endmodule

bind nack_gap_table_core ngt_checker u_ngt_checker (.*);

// ===== sim/nack_gap_table_core_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// nack_gap_table_core_tb
// Self-checking regression of the NACK gap table core.
// ============================================================================
//
// An initial block resets the core and then works through a series of
// phases. Each phase after the first programs the three timing registers
// while idle, then queues gap items: short directed runs, then random
// open, close and tick traffic around a moving clock. A clocked driver
// offers the queued items on the input stream. For every accepted transfer
// it runs a behavioural copy of the gap table, which appends the NACK
// results and the closing result of that item to a queue. A clocked monitor
// takes the result stream and compares each transfer, field by field, with
// the oldest queued result. Both sides idle in short random bursts, except
// in the final phase. Once, the result side holds off for a long stretch so
// that the core fills up and stalls its input. A watchdog ends the run if
// no transfer happens for too long.
//
module nack_gap_table_core_tb;

    import ngt_pkg::*;

    localparam int N_ENTRIES = GAP_ENTRIES_DEF;

    // The fourth func code has no meaning; the core only reports its count.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // Cycles without any transfer before the run is declared hung. The
    // slowest correct item is 33 results each behind a random stall plus
    // the table walk, and the deliberate hold-off lasts HOLD_CYCLES.
    localparam int HOLD_CYCLES = 500;
    localparam int QUIET_LIMIT = 5000;

    // Settling time after the last result before the registers change.
    localparam int SETTLE_CYCLES = N_ENTRIES + 8;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] now;
    } t_gap_item;

    typedef struct packed {
        logic             nack_valid;
        logic [SEQ_W-1:0] nack_seq;
        logic [CNT_W-1:0] active_count;
        logic             last;
    } t_nack_result;

    // ------------------------------------------------------------------------
    // Signals driven into the core. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    logic                  s_tready;
    logic                  m_tvalid;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tlast;

    always #4 clk = ~clk;

    nack_gap_table_core #(
        .GAP_ENTRIES (N_ENTRIES)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // seq_num, now_ms
        .i_s_axis_tuser  (s_tuser),   // func
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // nack_seq, active_count, zero pad
        .o_m_axis_tuser  (m_tuser),   // nack_valid
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Shared bookkeeping.
    // ------------------------------------------------------------------------
    t_gap_item    gap_items_todo[$];
    t_nack_result due_results[$];
    int           fail_count   = 0;
    bit           idle_on      = 1'b1;
    bit           pressure_req = 1'b0;

    // Behavioural copy of the table and of the timing registers.
    logic [CFG_W-1:0]  mirror_grace;
    logic [CFG_W-1:0]  mirror_retry;
    logic [CFG_W-1:0]  mirror_expire;
    logic [SEQ_W-1:0]  gap_seq     [N_ENTRIES];
    logic [TIME_W-1:0] gap_created [N_ENTRIES];
    logic [TIME_W-1:0] gap_last_req[N_ENTRIES];
    logic              gap_nacked  [N_ENTRIES];
    logic              gap_active  [N_ENTRIES];

    // State of the random traffic: a wandering clock and a pool of sequence
    // numbers a little larger than the table, so that it fills and evicts.
    logic [TIME_W-1:0] walk_now;
    logic [SEQ_W-1:0]  seq_base;

    function automatic int find_gap(input logic [SEQ_W-1:0] seq);
        int hit;
        hit = -1;
        for (int k = N_ENTRIES - 1; k >= 0; k--) begin
            if (gap_active[k] && gap_seq[k] == seq) begin
                hit = k;
            end
        end
        return hit;
    endfunction

    function automatic t_nack_result nack_of(input logic [SEQ_W-1:0] seq);
        t_nack_result r;
        r.nack_valid   = 1'b1;
        r.nack_seq     = seq;
        r.active_count = '0;
        r.last         = 1'b0;
        return r;
    endfunction

    // Applies one accepted item to the table copy and queues the results
    // the core owes for it: its NACKs in order, then the closing result.
    task automatic predict_nacks(input t_gap_item it);
        int                hit;
        int                pick;
        int                live;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] oldest;
        t_nack_result      closing;

        live   = 0;
        oldest = '0;
        case (it.func)
            FUNC_OPEN: begin
                if (find_gap(it.seq) < 0) begin
                    pick = -1;
                    for (int k = 0; k < N_ENTRIES; k++) begin
                        if (pick < 0 && !gap_active[k]) begin
                            pick = k;
                        end
                    end
                    // Full table: the oldest entry goes, lowest index on a tie.
                    if (pick < 0) begin
                        pick = 0;
                        for (int k = 0; k < N_ENTRIES; k++) begin
                            age = it.now - gap_created[k];
                            if (k == 0 || age > oldest) begin
                                oldest = age;
                                pick   = k;
                            end
                        end
                    end
                    gap_seq[pick]      = it.seq;
                    gap_created[pick]  = it.now;
                    gap_last_req[pick] = '0;
                    gap_nacked[pick]   = 1'b0;
                    gap_active[pick]   = 1'b1;
                end
                // Without a grace time the request goes out at once, even
                // when the gap was already known.
                if (mirror_grace == '0) begin
                    due_results.push_back(nack_of(it.seq));
                    hit = find_gap(it.seq);
                    if (hit >= 0) begin
                        gap_nacked[hit]   = 1'b1;
                        gap_last_req[hit] = it.now;
                    end
                end
            end
            FUNC_CLOSE: begin
                for (int k = 0; k < N_ENTRIES; k++) begin
                    if (gap_active[k] && gap_seq[k] == it.seq) begin
                        gap_active[k] = 1'b0;
                    end
                end
            end
            FUNC_TICK: begin
                for (int k = 0; k < N_ENTRIES; k++) begin
                    if (gap_active[k]) begin
                        age = it.now - gap_created[k];
                        if (age > {16'd0, mirror_expire}) begin
                            gap_active[k] = 1'b0;
                        end else if (age < {16'd0, mirror_grace}) begin
                            // Still within grace: leave it alone.
                        end else if (!gap_nacked[k]) begin
                            due_results.push_back(nack_of(gap_seq[k]));
                            gap_nacked[k]   = 1'b1;
                            gap_last_req[k] = it.now;
                        end else if (it.now - gap_last_req[k] >= {16'd0, mirror_retry}) begin
                            due_results.push_back(nack_of(gap_seq[k]));
                            gap_last_req[k] = it.now;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        for (int k = 0; k < N_ENTRIES; k++) begin
            if (gap_active[k]) begin
                live++;
            end
        end
        closing.nack_valid   = 1'b0;
        closing.nack_seq     = '0;
        closing.active_count = CNT_W'(live);
        closing.last         = 1'b1;
        due_results.push_back(closing);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers queued items and predicts each accepted transfer.
    // ------------------------------------------------------------------------
    t_gap_item drv_item;
    int        send_gap;

    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_nacks(drv_item);
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 7);
                    s_tvalid <= 1'b0;
                end else if (gap_items_todo.size() > 0) begin
                    drv_item = gap_items_todo.pop_front();
                    s_tdata  <= {drv_item.now, drv_item.seq};
                    s_tuser  <= drv_item.func;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each result transfer and paces tready. The long
    // hold-off is counted here once the stimulus asks for it.
    // ------------------------------------------------------------------------
    int           hold_left;
    int           stall_left;
    t_nack_result want;

    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            hold_left  = 0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual user %h data %h last %b",
                             $time, m_tuser, m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    if (m_tuser[0] !== want.nack_valid) begin
                        $display("%0t: nack_valid mismatch, expected %b actual %b",
                                 $time, want.nack_valid, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tdata[SEQ_W-1:0] !== want.nack_seq) begin
                        $display("%0t: nack_seq mismatch, expected %h actual %h",
                                 $time, want.nack_seq, m_tdata[SEQ_W-1:0]);
                        fail_count++;
                    end
                    if (m_tdata[SEQ_W+CNT_W-1:SEQ_W] !== want.active_count) begin
                        $display("%0t: active_count mismatch, expected %0d actual %0d",
                                 $time, want.active_count, m_tdata[SEQ_W+CNT_W-1:SEQ_W]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t: last mismatch, expected %b actual %b",
                                 $time, want.last, m_tlast);
                        fail_count++;
                    end
                end
            end

            if (pressure_req) begin
                pressure_req = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 7);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: counts cycles in which neither stream moves a transfer.
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("nack_gap_table_core regression: fail");
                $finish;
            end else begin
                quiet_cycles++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic add_item(input logic [FUNC_W-1:0] func, input logic [SEQ_W-1:0] seq,
                            input logic [TIME_W-1:0] now);
        t_gap_item it;
        it.func = func;
        it.seq  = seq;
        it.now  = now;
        gap_items_todo.push_back(it);
    endtask

    // Writes all three timing registers, one per cycle, and mirrors them.
    task automatic program_timers(input logic [CFG_W-1:0] grace,
                                  input logic [CFG_W-1:0] retry,
                                  input logic [CFG_W-1:0] expire);
        @(posedge clk);
        cfg_we       <= 1'b1;
        cfg_addr     <= REG_GRACE;
        cfg_wdata    <= grace;
        mirror_grace  = grace;
        @(posedge clk);
        cfg_addr     <= REG_RETRY;
        cfg_wdata    <= retry;
        mirror_retry  = retry;
        @(posedge clk);
        cfg_addr     <= REG_EXPIRE;
        cfg_wdata    <= expire;
        mirror_expire = expire;
        @(posedge clk);
        cfg_we       <= 1'b0;
    endtask

    // Waits until every queued item has been taken and answered, then lets
    // the core finish any trailing write-back before the next phase.
    task automatic drain_and_settle();
        do begin
            @(negedge clk);
        end while (gap_items_todo.size() != 0 || s_tvalid || due_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly well-formed traffic: a clock that creeps forward, often not at
    // all so that creation times tie, and sequence numbers from a small
    // pool. Now and then a wild jump in time or a sequence number far away.
    task automatic queue_random_items(input int count, input int step_max);
        int                r;
        logic [FUNC_W-1:0] func;
        logic [SEQ_W-1:0]  seq;

        walk_now = $urandom;
        seq_base = $urandom;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 19);
            if (r == 0) begin
                walk_now = $urandom;
            end else if (r > 5) begin
                walk_now = walk_now + $urandom_range(0, step_max);
            end
            r = $urandom_range(0, 99);
            if (r < 50) begin
                func = FUNC_OPEN;
            end else if (r < 65) begin
                func = FUNC_CLOSE;
            end else if (r < 95) begin
                func = FUNC_TICK;
            end else begin
                func = FUNC_UNUSED;
            end
            if (func == FUNC_TICK || $urandom_range(0, 15) == 0) begin
                seq = $urandom;
            end else begin
                seq = seq_base + $urandom_range(0, N_ENTRIES + 7);
            end
            add_item(func, seq, walk_now);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    logic [TIME_W-1:0] t0;
    logic [SEQ_W-1:0]  gap_a;

    initial begin
        mirror_grace  = GRACE_RST;
        mirror_retry  = RETRY_RST;
        mirror_expire = EXPIRE_RST;
        for (int k = 0; k < N_ENTRIES; k++) begin
            gap_seq[k]      = '0;
            gap_created[k]  = '0;
            gap_last_req[k] = '0;
            gap_nacked[k]   = 1'b0;
            gap_active[k]   = 1'b0;
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset timing: no grace, 25 ms retry, 200 ms expiry. The clock
        // starts just short of the wrap so that ages cross it.
        t0 = 32'hFFFF_FF00;
        add_item(FUNC_OPEN,   32'h0000_0000, t0);         // new gap, NACK at once
        add_item(FUNC_OPEN,   32'hFFFF_FFFF, t0);
        add_item(FUNC_OPEN,   32'h0000_0000, t0 + 1);     // already known, NACK again
        add_item(FUNC_CLOSE,  32'h0001_2345, t0 + 2);     // absent, no change
        add_item(FUNC_TICK,   32'hA5A5_5A5A, t0 + 10);    // retry not yet due
        add_item(FUNC_TICK,   32'h0000_0000, t0 + 40);    // both retried
        add_item(FUNC_CLOSE,  32'hFFFF_FFFF, t0 + 41);
        add_item(FUNC_UNUSED, 32'h1234_5678, t0 + 42);    // count only
        add_item(FUNC_TICK,   32'hFFFF_FFFF, t0 + 300);   // past the wrap: expired
        drain_and_settle();

        // With a grace time the first request waits for the tick that finds
        // the gap exactly grace old, and a zero retry repeats every tick.
        program_timers(16'd20, 16'd0, 16'hFFFF);
        gap_a = 32'h8000_0001;
        add_item(FUNC_OPEN,  gap_a,         32'h0000_1000);
        add_item(FUNC_TICK,  32'h0,         32'h0000_1005);  // within grace
        add_item(FUNC_TICK,  32'h0,         32'h0000_1014);  // first request
        add_item(FUNC_TICK,  32'h0,         32'h0000_1014);  // immediate retry
        add_item(FUNC_OPEN,  gap_a,         32'h0000_1015);  // known, nothing sent
        add_item(FUNC_OPEN,  32'h7FFF_FFFE, 32'h0000_1015);
        add_item(FUNC_CLOSE, gap_a,         32'h0000_1016);
        add_item(FUNC_TICK,  32'h0,         32'h0000_2000);
        drain_and_settle();

        program_timers(16'd5, 16'd12, 16'd150);
        queue_random_items(80, 10);
        drain_and_settle();

        // No grace, no retry spacing and the longest expiry: the table fills and
        // evicts. The result side is held off meanwhile to back up the core.
        program_timers(16'd0, 16'd0, 16'hFFFF);
        queue_random_items(80, 200);
        @(negedge clk);
        pressure_req = 1'b1;
        drain_and_settle();

        program_timers(16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_random_items(80, 4000);
        drain_and_settle();

        program_timers(16'd2, 16'd1, 16'd0);
        queue_random_items(80, 2);
        drain_and_settle();

        program_timers(CFG_W'($urandom_range(0, 300)), CFG_W'($urandom_range(0, 65535)),
                       CFG_W'($urandom_range(100, 65535)));
        queue_random_items(80, 300);
        drain_and_settle();

        // Final phase at full rate on both sides.
        program_timers(GRACE_RST, RETRY_RST, EXPIRE_RST);
        idle_on = 1'b0;
        queue_random_items(80, 15);
        drain_and_settle();

        if (fail_count == 0 && due_results.size() == 0) begin
            $display("nack_gap_table_core regression: pass");
        end else begin
            $display("nack_gap_table_core regression: fail");
        end
        $finish;
    end

endmodule
